// ===== design/mrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types and constants for the multidigit radix multiplier.
// ----------------------------------------------------------------------------
package mrm_pkg;

  localparam int DIGIT_W = 31;
  localparam int PROD_W  = 62;

  localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
  localparam logic [1:0] ACT_MULTIPLY    = 2'd2;

  localparam logic [2:0] ADDR_RADIX = 3'd0;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic latch_a;
    logic mul;
    logic add;
    logic div_step;
    logic carry_clr;
    logic wr_zero;
    logic wr_rem;
    logic wr_carry;
    logic out_load;
    logic out_last;
    logic counts_clr;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic digit_zero;
    logic out_taken;
  } stat_t;

endpackage

// ===== design/multidigit_radix_multiplier_top.sv =====
// ----------------------------------------------------------------------------
// multidigit_radix_multiplier_top
// Schoolbook multiprecision multiplier over a programmable radix.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid / in_ready    action, digit
//   output   out        out_valid / out_ready  product_digit, last, overflow
//   config   in         APB write, pready = 1  radix at byte address 0
//
// A multiply transfer first writes zero to all 2*MAX_DIGITS product words,
// then for each row clears the carry and latches the first-operand digit,
// and for each digit pair reads, multiplies, adds, runs 31 divide steps of
// one quotient bit per cycle in the radix divider and writes. Output stalls
// on out_ready, and leading zero digits are stripped before output.
// Reset is synchronous; it empties both operands and clears the recorded overflow.
// in_ready stays low from the multiply transfer until the last digit leaves.
// ----------------------------------------------------------------------------
module multidigit_radix_multiplier_top
  import mrm_pkg::*;
#(
  parameter int MAX_DIGITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [DIGIT_W-1:0] digit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DIGIT_W-1:0] product_digit,
  output logic               last,
  output logic               overflow,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int PW = $clog2(2 * MAX_DIGITS);

  logic [DIGIT_W-1:0] radix;
  logic [DIGIT_W-1:0] eff_radix;
  cmd_t               cmd;
  stat_t              stat;
  logic [AW-1:0]      a_addr, b_addr;
  logic [PW-1:0]      prod_addr;
  logic [CW-1:0]      first_count, second_count;

  // The register holds one word; only bit 2 of the byte address selects it.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_RADIX[2]) ? {1'b0, radix} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= '1;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_RADIX[2]) begin
      radix <= pwdata[DIGIT_W-1:0];
    end
  end

  // A radix of zero or one behaves as binary.
  assign eff_radix = (radix < DIGIT_W'(2)) ? DIGIT_W'(2) : radix;

  mrm_controller #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .first_count (first_count),
    .second_count(second_count),
    .stat        (stat),
    .cmd         (cmd),
    .a_addr      (a_addr),
    .b_addr      (b_addr),
    .prod_addr   (prod_addr)
  );

  mrm_datapath #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .eff_radix    (eff_radix),
    .digit        (digit),
    .a_addr       (a_addr),
    .b_addr       (b_addr),
    .prod_addr    (prod_addr),
    .first_count  (first_count),
    .second_count (second_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .product_digit(product_digit),
    .last         (last),
    .overflow     (overflow)
  );

endmodule

// ===== design/mrm_datapath.sv =====
// ----------------------------------------------------------------------------
// mrm_datapath
// Operand and product stores, digit multiplier, radix divider, output register.
// ----------------------------------------------------------------------------
module mrm_datapath
  import mrm_pkg::*;
#(
  parameter int MAX_DIGITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cmd_t                                 cmd,
  output stat_t                                stat,
  input  logic [DIGIT_W-1:0]                   eff_radix,
  input  logic [DIGIT_W-1:0]                   digit,
  input  logic [(MAX_DIGITS > 1 ? $clog2(MAX_DIGITS) : 1)-1:0] a_addr,
  input  logic [(MAX_DIGITS > 1 ? $clog2(MAX_DIGITS) : 1)-1:0] b_addr,
  input  logic [$clog2(2*MAX_DIGITS)-1:0]      prod_addr,
  output logic [$clog2(MAX_DIGITS+1)-1:0]      first_count,
  output logic [$clog2(MAX_DIGITS+1)-1:0]      second_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [DIGIT_W-1:0]                   product_digit,
  output logic                                 last,
  output logic                                 overflow
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int PD = 2 * MAX_DIGITS;
  localparam logic [CW-1:0] FULL = CW'(MAX_DIGITS);

  logic [DIGIT_W-1:0] first_mem  [MAX_DIGITS];
  logic [DIGIT_W-1:0] second_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] prod_mem   [PD];

  logic [DIGIT_W-1:0] first_q, second_q, prod_q;
  logic [DIGIT_W-1:0] a_reg, carry;
  logic [PROD_W-1:0]  prod;
  logic [DIGIT_W:0]   rem;
  logic [DIGIT_W-1:0] quo;
  logic [4:0]         div_cnt;
  logic               overflow_seen;

  logic [DIGIT_W-1:0] load_val, a_clamp, b_clamp, wr_data;
  logic [PROD_W-1:0]  sum;
  logic [DIGIT_W:0]   trial;
  logic               trial_ge;

  function automatic logic [DIGIT_W-1:0] clamp(input logic [DIGIT_W-1:0] d,
                                               input logic [DIGIT_W-1:0] r);
    clamp = (d >= r) ? r - DIGIT_W'(1) : d;
  endfunction

  assign load_val = clamp(digit, eff_radix);
  assign a_clamp  = clamp(first_q, eff_radix);
  assign b_clamp  = clamp(second_q, eff_radix);
  assign sum      = prod + PROD_W'(prod_q) + PROD_W'(carry);
  assign trial    = {rem[DIGIT_W-1:0], quo[DIGIT_W-1]};
  assign trial_ge = trial >= {1'b0, eff_radix};

  always_comb begin
    if (cmd.wr_rem) begin
      wr_data = rem[DIGIT_W-1:0];
    end else if (cmd.wr_carry) begin
      wr_data = carry;
    end else begin
      wr_data = '0;
    end
  end

  // Operand stores: written at the fill count, read every cycle.
  always_ff @(posedge clk) begin
    if (cmd.load_first && first_count != FULL) begin
      first_mem[first_count[AW-1:0]] <= load_val;
    end
    if (cmd.load_second && second_count != FULL) begin
      second_mem[second_count[AW-1:0]] <= load_val;
    end
    first_q  <= first_mem[a_addr];
    second_q <= second_mem[b_addr];
  end

  // Product store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_zero || cmd.wr_rem || cmd.wr_carry) begin
      prod_mem[prod_addr] <= wr_data;
    end
    prod_q <= prod_mem[prod_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.counts_clr) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.load_first) begin
        if (first_count == FULL) begin
          overflow_seen <= 1'b1;
        end else begin
          first_count <= first_count + CW'(1);
        end
      end
      if (cmd.load_second) begin
        if (second_count == FULL) begin
          overflow_seen <= 1'b1;
        end else begin
          second_count <= second_count + CW'(1);
        end
      end
    end
  end

  // Digit step: multiply, add partial and carry, then restoring division
  // one quotient bit per cycle. The quotient shifts into quo as the low half
  // of the dividend shifts out.
  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      a_reg <= a_clamp;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(a_reg) * PROD_W'(b_clamp);
    end
    if (cmd.carry_clr) begin
      carry <= '0;
    end else if (cmd.wr_rem) begin
      carry <= quo;
    end
    if (cmd.add) begin
      rem     <= {1'b0, sum[PROD_W-1:DIGIT_W]};
      quo     <= sum[DIGIT_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? trial - {1'b0, eff_radix} : trial;
      quo     <= {quo[DIGIT_W-2:0], trial_ge};
      div_cnt <= div_cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      product_digit <= prod_q;
      last          <= cmd.out_last;
      overflow      <= overflow_seen;
    end
  end

  assign stat.div_last   = div_cnt == 5'(DIGIT_W - 1);
  assign stat.digit_zero = prod_q == '0;
  assign stat.out_taken  = out_valid && out_ready;

endmodule

// ===== design/mrm_controller.sv =====
// ----------------------------------------------------------------------------
// mrm_controller
// Sequencer for loads, store clearing, the schoolbook loops and digit output.
// ----------------------------------------------------------------------------
module mrm_controller
  import mrm_pkg::*;
#(
  parameter int MAX_DIGITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           action,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]      first_count,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]      second_count,
  input  stat_t                                stat,
  output cmd_t                                 cmd,
  output logic [(MAX_DIGITS > 1 ? $clog2(MAX_DIGITS) : 1)-1:0] a_addr,
  output logic [(MAX_DIGITS > 1 ? $clog2(MAX_DIGITS) : 1)-1:0] b_addr,
  output logic [$clog2(2*MAX_DIGITS)-1:0]      prod_addr
);

  localparam int AW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW  = $clog2(MAX_DIGITS + 1);
  localparam int PW  = $clog2(2 * MAX_DIGITS);
  localparam int PCW = $clog2(2 * MAX_DIGITS + 1);
  localparam logic [PCW-1:0] CLR_END = PCW'(2 * MAX_DIGITS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_ROW   = 4'd2;
  localparam logic [3:0] S_ROWA  = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SMUL  = 4'd5;
  localparam logic [3:0] S_SADD  = 4'd6;
  localparam logic [3:0] S_SDIV  = 4'd7;
  localparam logic [3:0] S_SWR   = 4'd8;
  localparam logic [3:0] S_ERD   = 4'd9;
  localparam logic [3:0] S_ECHK  = 4'd10;
  localparam logic [3:0] S_EWAIT = 4'd11;

  logic [3:0]     state, state_next;
  logic [CW-1:0]  i, i_next, j, j_next;
  logic [PCW-1:0] k, k_next;
  logic           seen, seen_next;
  logic [PCW-1:0] i_plus_j, i_plus_n2, len_m1;
  logic           in_fire;

  assign in_ready  = state == S_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign i_plus_j  = PCW'(i) + PCW'(j);
  assign i_plus_n2 = PCW'(i) + PCW'(second_count);
  assign len_m1    = (first_count == '0 && second_count == '0) ? '0 :
                     PCW'(first_count) + PCW'(second_count) - PCW'(1);
  assign a_addr    = AW'(first_count - i - CW'(1));
  assign b_addr    = AW'(second_count - j - CW'(1));

  always_comb begin
    unique case (state)
      S_CLEAR, S_ERD: prod_addr = k[PW-1:0];
      S_SRD: prod_addr = (j == second_count) ? i_plus_n2[PW-1:0] : i_plus_j[PW-1:0];
      default: prod_addr = i_plus_j[PW-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    seen_next  = seen;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_first  = action == ACT_LOAD_FIRST;
          cmd.load_second = action == ACT_LOAD_SECOND;
          if (action == ACT_MULTIPLY) begin
            k_next     = '0;
            state_next = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd.wr_zero = 1'b1;
        k_next      = k + PCW'(1);
        if (k == CLR_END) begin
          i_next     = '0;
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        cmd.carry_clr = 1'b1;
        j_next        = '0;
        if (i == first_count) begin
          k_next     = len_m1;
          seen_next  = 1'b0;
          state_next = S_ERD;
        end else begin
          state_next = S_ROWA;
        end
      end
      S_ROWA: begin
        cmd.latch_a = 1'b1;
        state_next  = S_SRD;
      end
      S_SRD: begin
        if (j == second_count) begin
          cmd.wr_carry = 1'b1;
          i_next       = i + CW'(1);
          state_next   = S_ROW;
        end else begin
          state_next = S_SMUL;
        end
      end
      S_SMUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SADD;
      end
      S_SADD: begin
        cmd.add    = 1'b1;
        state_next = S_SDIV;
      end
      S_SDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_SWR;
        end
      end
      S_SWR: begin
        cmd.wr_rem = 1'b1;
        j_next     = j + CW'(1);
        state_next = S_SRD;
      end
      S_ERD: begin
        state_next = S_ECHK;
      end
      S_ECHK: begin
        if (stat.digit_zero && k != '0 && !seen) begin
          k_next     = k - PCW'(1);
          state_next = S_ERD;
        end else begin
          cmd.out_load = 1'b1;
          cmd.out_last = k == '0;
          seen_next    = 1'b1;
          state_next   = S_EWAIT;
        end
      end
      S_EWAIT: begin
        if (stat.out_taken) begin
          if (k == '0) begin
            cmd.counts_clr = 1'b1;
            state_next     = S_IDLE;
          end else begin
            k_next     = k - PCW'(1);
            state_next = S_ERD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      seen  <= 1'b0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      seen  <= seen_next;
    end
  end

endmodule

// ===== bench/mrm_product_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrm_product_checker
// Watches the input, output and register channels of the multiplier, keeps
// its own copy of both operands and the radix, predicts every product digit
// and compares each output transfer with the oldest expected digit.
// ----------------------------------------------------------------------------
module mrm_product_checker
  import mrm_pkg::*;
#(
  parameter int MAX_DIGITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         action,
  input  logic [DIGIT_W-1:0] digit,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [DIGIT_W-1:0] product_digit,
  input  logic               last,
  input  logic               overflow,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_digits,
  output int                 digits_seen,
  output int                 products_seen
);

  typedef struct packed {
    logic [DIGIT_W-1:0] value;
    logic               last;
    logic               overflow;
  } prod_digit_t;

  prod_digit_t        expected_digits[$];
  logic [DIGIT_W-1:0] radix_reg;
  logic [DIGIT_W-1:0] first_op[MAX_DIGITS];
  logic [DIGIT_W-1:0] second_op[MAX_DIGITS];
  int                 first_len;
  int                 second_len;
  logic               too_many;

  assign pending_digits = expected_digits.size();

  function automatic logic [63:0] base_of(input logic [DIGIT_W-1:0] r);
    return (r < 2) ? 64'd2 : 64'(r);
  endfunction

  function automatic logic [DIGIT_W-1:0] clip(input logic [63:0] d,
                                              input logic [63:0] r);
    return (d >= r) ? DIGIT_W'(r - 1) : DIGIT_W'(d);
  endfunction

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Schoolbook product, least significant digit first in acc.
  task automatic predict_product();
    logic [63:0] r, a, b, s, carry;
    logic [63:0] acc[2*MAX_DIGITS];
    int          len;
    prod_digit_t e;
    r = base_of(radix_reg);
    for (int k = 0; k < 2*MAX_DIGITS; k++) acc[k] = '0;
    for (int i = 0; i < first_len; i++) begin
      a = 64'(clip(64'(first_op[first_len-1-i]), r));
      carry = '0;
      for (int j = 0; j < second_len; j++) begin
        b = 64'(clip(64'(second_op[second_len-1-j]), r));
        s = a * b + acc[i+j] + carry;
        acc[i+j] = s % r;
        carry = s / r;
      end
      acc[i+second_len] = carry;
    end
    len = first_len + second_len;
    if (len == 0) len = 1;
    while (len > 1 && acc[len-1] == 0) len--;
    for (int k = len; k > 0; k--) begin
      e.value = DIGIT_W'(acc[k-1]);
      e.last = (k == 1);
      e.overflow = too_many;
      expected_digits.insert(expected_digits.size(), e);
    end
    first_len = 0;
    second_len = 0;
    too_many = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      radix_reg <= '1;
      first_len = 0;
      second_len = 0;
      too_many = 1'b0;
      fail_count = 0;
      digits_seen = 0;
      products_seen = 0;
      expected_digits.delete();
    end else begin
      if (in_valid && in_ready) begin
        case (action)
          ACT_LOAD_FIRST: begin
            if (first_len >= MAX_DIGITS) too_many = 1'b1;
            else first_op[first_len++] = clip(64'(digit), base_of(radix_reg));
          end
          ACT_LOAD_SECOND: begin
            if (second_len >= MAX_DIGITS) too_many = 1'b1;
            else second_op[second_len++] = clip(64'(digit), base_of(radix_reg));
          end
          ACT_MULTIPLY: begin
            predict_product();
            products_seen++;
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        digits_seen++;
        if (expected_digits.size() == 0) begin
          report("unexpected digit", 64'(product_digit), 64'd0);
        end else begin
          prod_digit_t e;
          e = expected_digits.pop_front();
          if (product_digit !== e.value)
            report("product_digit", 64'(product_digit), 64'(e.value));
          if (last !== e.last) report("last", 64'(last), 64'(e.last));
          if (overflow !== e.overflow) report("overflow", 64'(overflow), 64'(e.overflow));
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == ADDR_RADIX[2])
        radix_reg <= pwdata[DIGIT_W-1:0];
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the multidigit radix multiplier: directed operands at the
// digit and length extremes, then random operand pairs under several radix
// settings, with random gaps on both channels and a checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import mrm_pkg::*;

  localparam int MAX_DIGITS = 16;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         action = ACT_LOAD_FIRST;
  logic [DIGIT_W-1:0] digit = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [DIGIT_W-1:0] product_digit;
  logic               last;
  logic               overflow;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count, pending_digits, digits_seen, products_seen;
  int cycle_count = 0;
  int items_sent = 0;
  logic sink_enable = 0;

  always #1 clk = ~clk;

  multidigit_radix_multiplier_top #(.MAX_DIGITS(MAX_DIGITS)) dut (.*);

  mrm_product_checker #(.MAX_DIGITS(MAX_DIGITS)) checker_i (.*);

  // Random gap length: mostly short, occasionally long.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // The watchdog ends the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multidigit_radix_multiplier_top regression: fail");
      $finish;
    end
  end

  // The result side stalls at random, in bursts, with stretches always ready.
  always @(posedge clk) begin
    if (!sink_enable) out_ready <= 0;
    else if ($urandom_range(0, 3) == 0) out_ready <= ($urandom_range(0, 4) == 0);
    else out_ready <= 1;
  end

  // in_valid stays high after a transfer when the next item follows at once;
  // it drops only when a gap comes.
  task automatic send(input logic [1:0] act, input logic [DIGIT_W-1:0] d,
                      input bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    digit <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Lets the checker see the last transfer, then waits until the block is
  // ready again and every expected digit has come.
  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (pending_digits != 0 || !in_ready) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // A register write goes through a setup phase and then an access phase.
  task automatic write_radix(input logic [31:0] value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_RADIX; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  function automatic logic [DIGIT_W-1:0] rand_digit(input logic [31:0] r);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DIGIT_W'(r - 1);
      2: return DIGIT_W'($urandom);
      default: return DIGIT_W'($urandom_range(0, r - 1));
    endcase
  endfunction

  task automatic send_operands(input int n1, input int n2, input logic [31:0] r);
    int i1, i2;
    i1 = 0; i2 = 0;
    while (i1 < n1 || i2 < n2) begin
      if (i2 >= n2 || (i1 < n1 && $urandom_range(0, 1)))
        begin send(ACT_LOAD_FIRST, rand_digit(r), 1'($urandom_range(0, 1))); i1++; end
      else
        begin send(ACT_LOAD_SECOND, rand_digit(r), 1'($urandom_range(0, 1))); i2++; end
    end
  endtask

  logic [31:0] radix_set[6] = '{32'h7FFF_FFFF, 32'd2, 32'd10, 32'd0, 32'd1, 32'd65536};

  initial begin
    logic [31:0] r;
    repeat (5) @(posedge clk);
    rst <= 0;
    sink_enable <= 1;
    @(posedge clk);

    // Directed: both operands empty, then only one empty.
    send(ACT_MULTIPLY, '0);
    send(ACT_LOAD_FIRST, 31'd5);
    send(ACT_MULTIPLY, '1);
    // Largest digits in the reset radix, with a digit above radix-1 and a no-op.
    send(ACT_LOAD_FIRST, 31'h7FFF_FFFF);
    send(ACT_LOAD_FIRST, 31'h7FFF_FFFE);
    send(ACT_LOAD_SECOND, 31'h7FFF_FFFE);
    send(2'd3, 31'h5555_5555);
    send(ACT_LOAD_SECOND, 31'h2AAA_AAAA);
    send(ACT_MULTIPLY, '0);
    // A zero operand leaves leading zeros to strip.
    send(ACT_LOAD_FIRST, 31'd0);
    send(ACT_LOAD_FIRST, 31'd0);
    send(ACT_LOAD_SECOND, 31'd7);
    send(ACT_MULTIPLY, '0);
    wait_idle();

    // Full-length operands with one load past the limit on each.
    send_operands(MAX_DIGITS, MAX_DIGITS, 32'h7FFF_FFFF);
    send(ACT_LOAD_FIRST, 31'd1);
    send(ACT_LOAD_SECOND, 31'd1);
    send(ACT_MULTIPLY, '0);
    wait_idle();

    // Digits loaded under a large radix, multiplied under a small one.
    send(ACT_LOAD_FIRST, 31'd900);
    send(ACT_LOAD_SECOND, 31'd77);
    wait_idle();
    write_radix(32'd10);
    send(ACT_MULTIPLY, '0);

    // Random operand pairs across radix settings; most lengths are short.
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      r = radix_set[phase];
      write_radix(r);
      if (r < 2) r = 2;
      for (int p = 0; p < 4; p++) begin
        int n1, n2;
        n1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_DIGITS + 2)
                                         : $urandom_range(0, 3);
        n2 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_DIGITS + 2)
                                         : $urandom_range(0, 3);
        send_operands(n1, n2, r);
        if ($urandom_range(0, 5) == 0) send(2'd3, DIGIT_W'($urandom));
        send(ACT_MULTIPLY, DIGIT_W'($urandom));
        // Hold the sender until the product has drained completely.
        if (p == 2) wait_idle();
      end
    end

    wait_idle();
    write_radix(32'h7FFF_FFFF);
    send_operands(2, 2, 32'h7FFF_FFFF);
    send(ACT_MULTIPLY, '0);

    wait_idle();
    repeat (100) @(posedge clk);
    $display("Sent %0d input transfers forming %0d products; checked %0d digits.",
             items_sent, products_seen, digits_seen);
    $display("Radix settings covered the reset value, 0, 1, 2, 10 and 65536.");
    if (fail_count == 0 && pending_digits == 0)
      $display("multidigit_radix_multiplier_top regression: pass");
    else
      $display("multidigit_radix_multiplier_top regression: fail");
    $finish;
  end

endmodule
